[design/double_ended_queue_top_assert.svh]
// assertion helpers for the deque block, clocked on aclk and held off during reset
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define DQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/dq_pkg.sv]
package dq_pkg;

    localparam int FUNC_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam func_t FN_PUSH_FRONT = 3'd0;
    localparam func_t FN_PUSH_BACK  = 3'd1;
    localparam func_t FN_POP_FRONT  = 3'd2;
    localparam func_t FN_POP_BACK   = 3'd3;
    localparam func_t FN_READ_ALL   = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

[design/double_ended_queue_top.sv]
// Bounded double-ended queue of DEPTH signed 32-bit words held in a ring memory with a
// registered read port. Each input word carries an operation in s_tuser (push front, push
// back, pop front, pop back, read out all) and a push value in s_tdata. Every push or pop
// gives one result word with m_tlast set; m_tuser gives the status (ok, empty, full) and
// m_tdata the popped word, or zero. A read-out gives one result per entry from front to
// back with m_tlast on the final one, or a single empty result when the queue is empty.
// Operation codes 5 to 7 are dropped without a result. A push, and a pop or read-out of
// an empty queue, load the result register directly; a pop first reads the ring memory
// through its registered read port (state S_POP), and a read-out reads each entry in turn
// (states S_DUMP and S_DUMP_WAIT). One operation is handled at a time, each read-out entry
// waits for the output register to be free, and the next operation is taken once the last
// result of the current one sits in the output register and that register is empty or being
// read. The memory needs no clearing after reset, so the block is ready once aresetn rises.
module double_ended_queue_top
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value
    input  logic [2:0]  s_tuser,    // [2:0] func

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] value_out
    output logic [1:0]  m_tuser,    // [1:0] status
    output logic        m_tlast
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic [1:0] S_IDLE      = 2'd0;
    localparam logic [1:0] S_POP       = 2'd1;
    localparam logic [1:0] S_DUMP      = 2'd2;
    localparam logic [1:0] S_DUMP_WAIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [PTR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [PTR_W-1:0] idx_reg, idx_next;

    logic             m_valid_reg, m_valid_next;
    word_t            m_data_reg, m_data_next;
    status_t          m_status_reg, m_status_next;
    logic             m_last_reg, m_last_next;

    word_t            mem [DEPTH];
    word_t            rd_data_reg;
    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] wr_addr;
    logic             wr_en;

    logic             out_free;
    logic             s_acc;
    logic             full;
    logic             empty;
    logic             dump_last;
    func_t            s_func;

    // ring position base + off, off never above DEPTH
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign s_func    = func_t'(s_tuser);
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign s_acc     = s_tvalid && s_tready;
    assign full      = (occ_reg == CNT_W'(DEPTH));
    assign empty     = (occ_reg == '0);
    assign dump_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == occ_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        state_next    = state_reg;
        front_next    = front_reg;
        occ_next      = occ_reg;
        idx_next      = idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        wr_en         = 1'b0;
        wr_addr       = ring_add(front_reg, occ_reg);
        rd_addr       = front_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    // single-word results by default
                    m_data_next   = '0;
                    m_status_next = ST_OK;
                    m_last_next   = 1'b1;
                    case (s_func)
                        FN_PUSH_FRONT: begin
                            m_valid_next = 1'b1;
                            if (full) begin
                                m_status_next = ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = ring_add(front_reg, CNT_W'(DEPTH - 1));
                                front_next = wr_addr;
                                occ_next   = occ_reg + CNT_W'(1);
                            end
                        end
                        FN_PUSH_BACK: begin
                            m_valid_next = 1'b1;
                            if (full) begin
                                m_status_next = ST_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        FN_POP_FRONT: begin
                            if (empty) begin
                                m_valid_next  = 1'b1;
                                m_status_next = ST_EMPTY;
                            end else begin
                                rd_addr    = front_reg;
                                front_next = ring_add(front_reg, CNT_W'(1));
                                occ_next   = occ_reg - CNT_W'(1);
                                state_next = S_POP;
                            end
                        end
                        FN_POP_BACK: begin
                            if (empty) begin
                                m_valid_next  = 1'b1;
                                m_status_next = ST_EMPTY;
                            end else begin
                                rd_addr    = ring_add(front_reg, occ_reg - CNT_W'(1));
                                occ_next   = occ_reg - CNT_W'(1);
                                state_next = S_POP;
                            end
                        end
                        FN_READ_ALL: begin
                            if (empty) begin
                                m_valid_next  = 1'b1;
                                m_status_next = ST_EMPTY;
                            end else begin
                                idx_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POP: begin
                // output register was free when the pop was taken
                m_valid_next  = 1'b1;
                m_data_next   = rd_data_reg;
                m_status_next = ST_OK;
                m_last_next   = 1'b1;
                state_next    = S_IDLE;
            end
            S_DUMP: begin
                if (out_free) begin
                    rd_addr    = ring_add(front_reg, CNT_W'(idx_reg));
                    state_next = S_DUMP_WAIT;
                end
            end
            S_DUMP_WAIT: begin
                m_valid_next  = 1'b1;
                m_data_next   = rd_data_reg;
                m_status_next = ST_OK;
                m_last_next   = dump_last;
                if (dump_last) begin
                    state_next = S_IDLE;
                end else begin
                    idx_next   = idx_reg + PTR_W'(1);
                    state_next = S_DUMP;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            occ_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            occ_reg     <= occ_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    // ring memory: one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= word_t'(s_tdata);
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

`include "double_ended_queue_top_assert.svh"

    `DQ_ASSERT_SAME(a_occ_bound, 1'b1, occ_reg <= CNT_W'(DEPTH),
        "occupancy above depth")
    `DQ_ASSERT_SAME(a_busy_no_take, state_reg != S_IDLE, !s_tready,
        "word taken while an operation is in progress")
    `DQ_ASSERT_NEXT(a_push_count, s_acc && s_func == FN_PUSH_BACK && !full,
        occ_reg == $past(occ_reg) + CNT_W'(1), "push did not raise occupancy")
    `DQ_ASSERT_NEXT(a_pop_result, state_reg == S_POP,
        m_valid_reg && m_last_reg && m_status_reg == ST_OK, "pop result not loaded")
    `DQ_ASSERT_NEXT(a_dump_end, state_reg == S_DUMP_WAIT && dump_last,
        m_valid_reg && m_last_reg && state_reg == S_IDLE, "read-out did not close")

endmodule

[bench/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_OPS = 110;
    localparam func_t FN_UNUSED_LO = FN_READ_ALL + 1'b1;
    localparam func_t FN_UNUSED_HI = '1;

    typedef struct {
        word_t   word;
        status_t status;
        logic    last;
    } deque_result_t;

    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_tvalid = 1'b0;
    logic    s_tready;
    word_t   s_tdata = '0;
    func_t   s_tuser = FN_PUSH_FRONT;
    logic    m_tvalid;
    logic    m_tready = 1'b0;
    word_t   m_tdata;
    status_t m_tuser;
    logic    m_tlast;

    // mirror of the ring store
    word_t ring_mem [QUEUE_DEPTH];
    int    head_pos = 0;
    int    fill = 0;

    deque_result_t expected_words [$];

    int idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;
    int result_count = 0;
    int push_count = 0;
    int pop_count = 0;
    int readout_count = 0;
    int unused_count = 0;
    int full_hits = 0;
    int empty_hits = 0;

    double_ended_queue_top #(
        .DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_words.size());
            $display("[double_ended_queue_top] ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= 50)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic void push_result(word_t w, status_t st, logic lst);
        deque_result_t r;
        r.word = w;
        r.status = st;
        r.last = lst;
        expected_words.push_back(r);
    endfunction

    // works out the result words of one accepted operation and updates the mirror
    function automatic void deque_apply(func_t op, word_t data);
        case (op)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
                push_count++;
                if (fill == QUEUE_DEPTH) begin
                    full_hits++;
                    push_result('0, ST_FULL, 1'b1);
                end else begin
                    if (op == FN_PUSH_FRONT) begin
                        head_pos = (head_pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                        ring_mem[head_pos] = data;
                    end else begin
                        ring_mem[(head_pos + fill) % QUEUE_DEPTH] = data;
                    end
                    fill++;
                    push_result('0, ST_OK, 1'b1);
                end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
                pop_count++;
                if (fill == 0) begin
                    empty_hits++;
                    push_result('0, ST_EMPTY, 1'b1);
                end else if (op == FN_POP_FRONT) begin
                    push_result(ring_mem[head_pos], ST_OK, 1'b1);
                    head_pos = (head_pos + 1) % QUEUE_DEPTH;
                    fill--;
                end else begin
                    push_result(ring_mem[(head_pos + fill - 1) % QUEUE_DEPTH], ST_OK, 1'b1);
                    fill--;
                end
            end
            FN_READ_ALL: begin
                readout_count++;
                if (fill == 0) begin
                    empty_hits++;
                    push_result('0, ST_EMPTY, 1'b1);
                end else begin
                    for (int k = 0; k < fill; k++)
                        push_result(ring_mem[(head_pos + k) % QUEUE_DEPTH], ST_OK,
                                    k == fill - 1);
                end
            end
            default: begin
                // unused codes are dropped by the block
                unused_count++;
            end
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_op(func_t op, word_t data);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        deque_apply(op, data);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin : result_check
        deque_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected result word data=%h status=%0d last=%b",
                                          m_tdata, m_tuser, m_tlast));
            end else begin
                want = expected_words.pop_front();
                if (m_tdata !== want.word)
                    report_mismatch($sformatf("data %h, expected %h", m_tdata, want.word));
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_tuser, want.status));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
            end
        end
    end

    task automatic test_empty_queue();
        send_op(FN_POP_FRONT, '1);
        send_op(FN_POP_BACK, '0);
        send_op(FN_READ_ALL, 32'h8000_0000);
        for (int f = FN_UNUSED_LO; f <= FN_UNUSED_HI; f++)
            send_op(func_t'(f), $urandom());
    endtask

    // fills from both ends, the first eight words with extreme values, then knocks on a full queue and reads it out
    task automatic test_fill_to_full();
        word_t corner [4];
        corner[0] = 32'h8000_0000;
        corner[1] = 32'h7fff_ffff;
        corner[2] = 32'h0000_0000;
        corner[3] = 32'hffff_ffff;
        for (int k = 0; k < QUEUE_DEPTH; k++)
            send_op(k[0] ? FN_PUSH_BACK : FN_PUSH_FRONT,
                    (k < 8) ? corner[k % 4] : $urandom());
        send_op(FN_PUSH_FRONT, 32'h1234_5678);
        send_op(FN_PUSH_BACK, 32'h8765_4321);
        send_op(FN_READ_ALL, '0);
    endtask

    // bursts biased towards filling or draining so both ends and wrap-around get hit
    task automatic test_random_traffic(int sender_idle, int receiver_stall, int n_ops);
        int done;
        int push_bias;
        int pick;
        func_t op;
        done = 0;
        push_bias = 50;
        idle_pct = sender_idle;
        stall_pct = receiver_stall;
        while (done < n_ops) begin
            if (done % 20 == 0) begin
                case ($urandom_range(2))
                    0: push_bias = 75;
                    1: push_bias = 25;
                    default: push_bias = 50;
                endcase
            end
            pick = $urandom_range(99);
            if (pick < 3) begin
                op = func_t'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
            end else begin
                if (pick < 11)
                    op = FN_READ_ALL;
                else if ($urandom_range(99) < push_bias)
                    op = $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
                else
                    op = $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
                done++;
            end
            send_op(op, $urandom());
        end
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_queue();
        test_fill_to_full();
        test_random_traffic(0, 0, RANDOM_OPS);
        test_random_traffic(76, 0, RANDOM_OPS);
        test_random_traffic(0, 76, RANDOM_OPS);
        test_random_traffic(9, 9, RANDOM_OPS);

        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("ran %0d pushes, %0d pops, %0d read-outs and %0d unused codes; %0d words checked",
                 push_count, pop_count, readout_count, unused_count, result_count);
        $display("queue seen full %0d times and empty %0d times over four handshake mixes",
                 full_hits, empty_hits);
        if (error_count == 0)
            $display("[double_ended_queue_top] OK");
        else
            $display("[double_ended_queue_top] ERROR");
        $finish;
    end

endmodule
